/* rtl/core/assert_macros.svh */
// assertion macros included by the extractor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* rtl/core/apse_pkg.sv */
// types and constants of the annex b parameter set extractor
package apse_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int TYPE_W   = 5;
    localparam int LEN_W    = 7;
    localparam int RUN_W    = 8;
    localparam int WIDE_W   = 9;

    localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1f;
    localparam logic [RUN_W-1:0]  RUN_MAX       = 8'hff;

    localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
    localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_STREAM   = 2'd0,
        ACT_READ_SPS = 2'd1,
        ACT_READ_PPS = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ZERO1 = 4'b0010,
        ST_ZERO2 = 4'b0100,
        ST_HIT   = 4'b1000
    } scan_state_t;

    typedef struct packed {
        logic              idr_seen;
        logic              sets_ready;
        logic [TYPE_W-1:0] unit_type;
        logic [LEN_W-1:0]  sps_length;
        logic [LEN_W-1:0]  pps_length;
    } result_t;

    typedef struct packed {
        logic sps;
        logic pps;
    } read_sel_t;

endpackage

/* rtl/core/apse_in_if.sv */
// request channel carrying stream bytes and store reads
interface apse_in_if;
    import apse_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic [INDEX_W-1:0]  read_index;

    modport source (output valid, action, data_byte, read_index, input ready);
    modport sink (input valid, action, data_byte, read_index, output ready);
endinterface

/* rtl/core/apse_out_if.sv */
// result channel carrying per-request status and read data
interface apse_out_if;
    import apse_pkg::*;

    logic              valid;
    logic              ready;
    logic              idr_seen;
    logic              sets_ready;
    logic [TYPE_W-1:0] unit_type;
    logic [LEN_W-1:0]  sps_length;
    logic [LEN_W-1:0]  pps_length;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, idr_seen, sets_ready, unit_type, sps_length, pps_length,
                    read_data, input ready);
    modport sink (input valid, idr_seen, sets_ready, unit_type, sps_length, pps_length,
                  read_data, output ready);
endinterface

/* rtl/core/apse_ram.sv */
// generic single write port ram with registered read
module apse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* rtl/core/annexb_parameter_set_extractor_core.sv */
// top level of the annex b parameter set extractor
// Takes one request per clock as long as results are taken: a stream byte or a read of a
// stored SPS/PPS byte. Every request yields exactly one result, in order, through the
// s1 register and the output register; the s1 stage is the registered read of the
// SPS/PPS stores. A result register behind the store read lets one result wait while
// the next request still enters. Start codes are found by a four-state scanner, SPS and
// PPS bytes are kept up to SPS_DEPTH and PPS_DEPTH, and an IDR header reports whether
// both parameter sets are held. The stores need no clearing.
module annexb_parameter_set_extractor_core #(
    parameter int SPS_DEPTH = 64,
    parameter int PPS_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    apse_in_if.sink   stream,
    apse_out_if.source result
);
    import apse_pkg::*;
    `include "assert_macros.svh"

    localparam int SPS_AW = $clog2(SPS_DEPTH);
    localparam int PPS_AW = $clog2(PPS_DEPTH);
    localparam int SPS_CW = $clog2(SPS_DEPTH + 1);
    localparam int PPS_CW = $clog2(PPS_DEPTH + 1);

    scan_state_t       state_reg, state_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [SPS_CW-1:0] sps_count_reg, sps_count_next;
    logic [PPS_CW-1:0] pps_count_reg, pps_count_next;

    logic              s1_valid_reg, s1_valid_next;
    result_t           s1_res_reg, s1_res_next;
    read_sel_t         s1_sel_reg, s1_sel_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg, out_res_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;

    logic              accept;
    logic              s1_move;
    logic              header;
    logic              idr;
    logic              sets_ready;
    logic [RUN_W-1:0]  run_inc;
    logic [WIDE_W-1:0] run_wide;
    logic [WIDE_W-1:0] sps_wide;
    logic [WIDE_W-1:0] pps_wide;
    logic [WIDE_W-1:0] index_wide;
    logic              sps_wr, pps_wr;
    read_sel_t         sel;
    logic [BYTE_W-1:0] sps_rd_data, pps_rd_data;
    logic [BYTE_W-1:0] byte_in;

    assign byte_in    = stream.data_byte;
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign accept     = stream.valid && stream.ready;
    assign stream.ready = !s1_valid_reg || s1_move;

    assign run_inc    = (run_reg != RUN_MAX) ? run_reg + 8'd1 : run_reg;
    assign run_wide   = WIDE_W'(run_reg);
    assign sps_wide   = WIDE_W'(sps_count_reg);
    assign pps_wide   = WIDE_W'(pps_count_reg);
    assign index_wide = WIDE_W'(stream.read_index);

    always_comb
    begin
        state_next     = state_reg;
        run_next       = run_reg;
        type_next      = type_reg;
        sps_count_next = sps_count_reg;
        pps_count_next = pps_count_reg;
        header         = 1'b0;
        idr            = 1'b0;
        sets_ready     = 1'b0;
        sps_wr         = 1'b0;
        pps_wr         = 1'b0;
        sel            = '0;
        if (accept)
        begin
            case (action_t'(stream.action))
                ACT_STREAM:
                begin
                    case (state_reg)
                        ST_IDLE:
                        begin
                            if (byte_in == 8'h00)
                            begin
                                state_next = ST_ZERO1;
                                run_next   = 8'd1;
                            end
                            else
                            begin
                                run_next = '0;
                            end
                        end
                        ST_ZERO1:
                        begin
                            if (byte_in == 8'h00)
                            begin
                                state_next = ST_ZERO2;
                                run_next   = run_inc;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                                run_next   = '0;
                            end
                        end
                        ST_ZERO2:
                        begin
                            if (byte_in == 8'h00)
                            begin
                                run_next = run_inc;
                            end
                            else if (byte_in == 8'h01)
                            begin
                                state_next = ST_HIT;
                                run_next   = run_inc;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                                run_next   = '0;
                            end
                        end
                        ST_HIT:
                        begin
                            header     = 1'b1;
                            state_next = ST_IDLE;
                            run_next   = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                            run_next   = '0;
                        end
                    endcase

                    if (header)
                    begin
                        // trim trailing start code bytes off the finished unit
                        if (type_reg == NAL_SPS)
                        begin
                            sps_count_next = (sps_wide > run_wide) ?
                                SPS_CW'(sps_wide - run_wide) : '0;
                        end
                        else if (type_reg == NAL_PPS)
                        begin
                            pps_count_next = (pps_wide > run_wide) ?
                                PPS_CW'(pps_wide - run_wide) : '0;
                        end
                        type_next = TYPE_W'(byte_in & NAL_TYPE_MASK);
                        if (type_next == NAL_SPS)
                        begin
                            sps_count_next = '0;
                        end
                        else if (type_next == NAL_PPS)
                        begin
                            pps_count_next = '0;
                        end
                        if (type_next == NAL_IDR)
                        begin
                            idr        = 1'b1;
                            sets_ready = (sps_count_next != '0) && (pps_count_next != '0);
                            type_next  = '0;
                        end
                    end
                    else if (type_reg == NAL_SPS)
                    begin
                        if (sps_count_reg < SPS_CW'(SPS_DEPTH))
                        begin
                            sps_wr         = 1'b1;
                            sps_count_next = sps_count_reg + SPS_CW'(1);
                        end
                    end
                    else if (type_reg == NAL_PPS)
                    begin
                        if (pps_count_reg < PPS_CW'(PPS_DEPTH))
                        begin
                            pps_wr         = 1'b1;
                            pps_count_next = pps_count_reg + PPS_CW'(1);
                        end
                    end
                end
                ACT_READ_SPS:
                begin
                    sel.sps = index_wide < WIDE_W'(SPS_DEPTH);
                end
                ACT_READ_PPS:
                begin
                    sel.pps = index_wide < WIDE_W'(PPS_DEPTH);
                end
                default:
                begin
                end
            endcase
        end
    end

    apse_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SPS_DEPTH)
    ) u_sps_ram (
        .clk     (clk),
        .wr_en   (sps_wr),
        .wr_addr (sps_count_reg[SPS_AW-1:0]),
        .wr_data (byte_in),
        .rd_en   (accept),
        .rd_addr (index_wide[SPS_AW-1:0]),
        .rd_data (sps_rd_data)
    );

    apse_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PPS_DEPTH)
    ) u_pps_ram (
        .clk     (clk),
        .wr_en   (pps_wr),
        .wr_addr (pps_count_reg[PPS_AW-1:0]),
        .wr_data (byte_in),
        .rd_en   (accept),
        .rd_addr (index_wide[PPS_AW-1:0]),
        .rd_data (pps_rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_res_next   = s1_res_reg;
        s1_sel_next   = s1_sel_reg;
        if (accept)
        begin
            s1_valid_next          = 1'b1;
            s1_res_next.idr_seen   = idr;
            s1_res_next.sets_ready = sets_ready;
            s1_res_next.unit_type  = type_next;
            s1_res_next.sps_length = LEN_W'(sps_count_next);
            s1_res_next.pps_length = LEN_W'(pps_count_next);
            s1_sel_next            = sel;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_data_next  = out_data_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            out_res_next   = s1_res_reg;
            if (s1_sel_reg.sps)
            begin
                out_data_next = sps_rd_data;
            end
            else if (s1_sel_reg.pps)
            begin
                out_data_next = pps_rd_data;
            end
            else
            begin
                out_data_next = '0;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            type_reg      <= '0;
            sps_count_reg <= '0;
            pps_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            type_reg      <= type_next;
            sps_count_reg <= sps_count_next;
            pps_count_reg <= pps_count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg   <= s1_res_next;
        s1_sel_reg   <= s1_sel_next;
        out_res_reg  <= out_res_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.idr_seen   = out_res_reg.idr_seen;
    assign result.sets_ready = out_res_reg.sets_ready;
    assign result.unit_type  = out_res_reg.unit_type;
    assign result.sps_length = out_res_reg.sps_length;
    assign result.pps_length = out_res_reg.pps_length;
    assign result.read_data  = out_data_reg;

    `ASSERT_ALWAYS(a_sps_count_bound, sps_count_reg <= SPS_CW'(SPS_DEPTH),
        "sps count beyond store depth")
    `ASSERT_ALWAYS(a_pps_count_bound, pps_count_reg <= PPS_CW'(PPS_DEPTH),
        "pps count beyond store depth")
    `ASSERT_IMPLY(a_stall_blocks_intake, s1_valid_reg && !s1_move, !stream.ready,
        "request taken while read stage is stalled")
    `ASSERT_IMPLY(a_idr_clears_type, result.valid && result.idr_seen, result.unit_type == '0,
        "unit type not cleared after idr")
    `ASSERT_IMPLY(a_ready_needs_idr, result.valid && result.sets_ready, result.idr_seen,
        "sets ready reported outside an idr header")
endmodule

/* bench/apse_stream_checker.sv */
// checker that predicts and compares every result of the parameter set extractor
module apse_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    apse_in_if          stream,
    apse_out_if         result,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output logic [63:0] sps_written,
    output logic [63:0] pps_written
);
    timeunit 1ns;
    timeprecision 1ps;
    import apse_pkg::*;

    localparam int STORE_DEPTH = 64;

    typedef struct packed {
        result_t           status;
        logic [BYTE_W-1:0] read_data;
    } report_t;

    scan_state_t       scan_q;
    logic [RUN_W-1:0]  run_q;
    logic [TYPE_W-1:0] type_q;
    logic [BYTE_W-1:0] sps_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] pps_mem [STORE_DEPTH];
    int unsigned       sps_cnt;
    int unsigned       pps_cnt;
    report_t           pending_reports [$];
    report_t           want;
    report_t           fresh;

    function automatic logic [RUN_W-1:0] bumped(input logic [RUN_W-1:0] run);
        return (run == RUN_MAX) ? run : run + 1'b1;
    endfunction

    function automatic int unsigned trimmed(input int unsigned cnt, input logic [RUN_W-1:0] run);
        return (cnt > run) ? cnt - run : 0;
    endfunction

    task automatic extract_step(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                                input logic [INDEX_W-1:0] idx, output report_t rep);
        logic header;
        rep = '0;
        header = 1'b0;
        if (act == ACT_READ_SPS)
        begin
            rep.read_data = sps_mem[idx];
        end
        else if (act == ACT_READ_PPS)
        begin
            rep.read_data = pps_mem[idx];
        end
        else if (act == ACT_STREAM)
        begin
            case (scan_q)
                ST_IDLE:
                begin
                    if (b == '0)
                    begin
                        scan_q = ST_ZERO1;
                        run_q = 8'd1;
                    end
                    else
                    begin
                        run_q = '0;
                    end
                end
                ST_ZERO1:
                begin
                    if (b == '0)
                    begin
                        scan_q = ST_ZERO2;
                        run_q = bumped(run_q);
                    end
                    else
                    begin
                        scan_q = ST_IDLE;
                        run_q = '0;
                    end
                end
                ST_ZERO2:
                begin
                    if (b == '0)
                    begin
                        run_q = bumped(run_q);
                    end
                    else if (b == 8'h01)
                    begin
                        scan_q = ST_HIT;
                        run_q = bumped(run_q);
                    end
                    else
                    begin
                        scan_q = ST_IDLE;
                        run_q = '0;
                    end
                end
                default:
                begin
                    header = 1'b1;
                    // drop the start code that was stored at the tail of the last unit
                    if (type_q == NAL_SPS)
                        sps_cnt = trimmed(sps_cnt, run_q);
                    else if (type_q == NAL_PPS)
                        pps_cnt = trimmed(pps_cnt, run_q);
                    type_q = TYPE_W'(b & NAL_TYPE_MASK);
                    if (type_q == NAL_SPS)
                        sps_cnt = 0;
                    else if (type_q == NAL_PPS)
                        pps_cnt = 0;
                    scan_q = ST_IDLE;
                    run_q = '0;
                end
            endcase
            if (!header)
            begin
                if (type_q == NAL_SPS && sps_cnt < STORE_DEPTH)
                begin
                    sps_mem[INDEX_W'(sps_cnt)] = b;
                    sps_written[INDEX_W'(sps_cnt)] = 1'b1;
                    sps_cnt++;
                end
                else if (type_q == NAL_PPS && pps_cnt < STORE_DEPTH)
                begin
                    pps_mem[INDEX_W'(pps_cnt)] = b;
                    pps_written[INDEX_W'(pps_cnt)] = 1'b1;
                    pps_cnt++;
                end
            end
            else if (type_q == NAL_IDR)
            begin
                rep.status.idr_seen = 1'b1;
                rep.status.sets_ready = (sps_cnt != 0 && pps_cnt != 0);
                type_q = '0;
            end
        end
        rep.status.unit_type = type_q;
        rep.status.sps_length = LEN_W'(sps_cnt);
        rep.status.pps_length = LEN_W'(pps_cnt);
    endtask

    task automatic compare_field(input string fname, input logic [7:0] expv,
                                 input logic [7:0] actv);
        if (actv !== expv)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, fname, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_q = ST_IDLE;
            run_q = '0;
            type_q = '0;
            sps_cnt = 0;
            pps_cnt = 0;
            sps_written = '0;
            pps_written = '0;
            pending_reports.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t unexpected result with no request outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    compare_field("idr_seen", 8'(want.status.idr_seen), 8'(result.idr_seen));
                    compare_field("sets_ready", 8'(want.status.sets_ready),
                                  8'(result.sets_ready));
                    compare_field("unit_type", 8'(want.status.unit_type), 8'(result.unit_type));
                    compare_field("sps_length", 8'(want.status.sps_length),
                                  8'(result.sps_length));
                    compare_field("pps_length", 8'(want.status.pps_length),
                                  8'(result.pps_length));
                    compare_field("read_data", want.read_data, result.read_data);
                end
            end
            if (stream.valid && stream.ready)
            begin
                extract_step(stream.action, stream.data_byte, stream.read_index, fresh);
                pending_reports.push_back(fresh);
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

/* bench/testbench.sv */
// stimulus, clock, reset and verdict for the parameter set extractor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import apse_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;

    logic        clk;
    logic        rst_n;
    logic        steady;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches;
    int unsigned outstanding;
    logic [63:0] sps_written;
    logic [63:0] pps_written;

    apse_in_if  stream_if ();
    apse_out_if result_if ();

    annexb_parameter_set_extractor_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    apse_stream_checker stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_if),
        .result      (result_if),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .sps_written (sps_written),
        .pps_written (pps_written)
    );

    // no idling on either side through this window
    assign steady = (sent >= 300 && sent < 550);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        result_if.ready <= steady || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stream_if.valid && stream_if.ready)
                sent <= sent + 1;
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("annexb_parameter_set_extractor_core regression: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_request(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] dbyte,
                                input logic [INDEX_W-1:0] idx);
        while (!steady && $urandom_range(99) < 21)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid <= 1'b1;
        stream_if.action <= act;
        stream_if.data_byte <= dbyte;
        stream_if.read_index <= idx;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stream_byte(input logic [BYTE_W-1:0] b);
        push_request(ACT_STREAM, b, INDEX_W'($urandom_range(63)));
    endtask

    task automatic start_code(input int zeros);
        repeat (zeros) stream_byte(8'h00);
        stream_byte(8'h01);
    endtask

    function automatic logic [BYTE_W-1:0] header_for(input logic [TYPE_W-1:0] t);
        logic [2:0] hi;
        hi = 3'($urandom_range(7));
        return {hi, t};
    endfunction

    // zeros and ones often enough to form start codes inside payloads
    function automatic logic [BYTE_W-1:0] payload_byte();
        int unsigned r;
        r = $urandom_range(11);
        if (r < 2)
            return 8'h00;
        else if (r == 2)
            return 8'h01;
        return 8'($urandom_range(255));
    endfunction

    task automatic read_store(input bit from_pps);
        logic [63:0] mask;
        int unsigned idx;
        mask = from_pps ? pps_written : sps_written;
        if (mask == '0)
        begin
            push_request(ACT_UNKNOWN, 8'($urandom_range(255)), INDEX_W'($urandom_range(63)));
        end
        else
        begin
            do idx = $urandom_range(63); while (!mask[idx]);
            push_request(from_pps ? ACT_READ_PPS : ACT_READ_SPS, 8'($urandom_range(255)),
                         INDEX_W'(idx));
        end
    endtask

    task automatic send_unit();
        int unsigned r;
        logic [TYPE_W-1:0] t;
        int unsigned len;
        r = $urandom_range(99);
        if (r < 25)
            t = NAL_SPS;
        else if (r < 50)
            t = NAL_PPS;
        else if (r < 70)
            t = NAL_IDR;
        else
            t = TYPE_W'($urandom_range(31));
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 72) : $urandom_range(12);
        start_code($urandom_range(2, 4));
        stream_byte(header_for(t));
        repeat (len) stream_byte(payload_byte());
    endtask

    initial
    begin
        int unsigned base;
        int unsigned pick;
        bit drained;
        stream_if.valid = 1'b0;
        stream_if.action = ACT_STREAM;
        stream_if.data_byte = '0;
        stream_if.read_index = '0;
        drained = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_request(ACT_UNKNOWN, 8'hff, 6'h3f);
        start_code(3);
        stream_byte({3'b011, NAL_SPS});
        stream_byte(8'hff);
        stream_byte(8'h80);
        start_code(2);
        stream_byte({3'b011, NAL_PPS});
        stream_byte(8'h55);
        start_code(2);
        stream_byte({3'b011, NAL_IDR});
        push_request(ACT_READ_SPS, 8'h00, 6'd0);
        push_request(ACT_READ_SPS, 8'hff, 6'd1);
        push_request(ACT_READ_PPS, 8'h00, 6'd0);
        start_code(2);
        stream_byte({3'b111, NAL_SPS});
        start_code(2);
        stream_byte({3'b000, NAL_IDR});

        base = sent;
        // overfill both stores, then a start run long enough to saturate
        start_code(3);
        stream_byte(header_for(NAL_SPS));
        repeat (70) stream_byte(8'($urandom_range(1, 255)));
        repeat (300) stream_byte(8'h00);
        stream_byte(8'h01);
        stream_byte(header_for(NAL_PPS));
        repeat (70) stream_byte(8'($urandom_range(1, 255)));
        start_code(2);
        stream_byte(header_for(NAL_IDR));
        push_request(ACT_READ_SPS, 8'($urandom_range(255)), 6'd63);
        push_request(ACT_READ_PPS, 8'($urandom_range(255)), 6'd63);

        while (sent < base + RANDOM_ITEMS)
        begin
            if (!drained && sent >= base + 700)
            begin
                drained = 1'b1;
                while (outstanding != 0)
                begin
                    stream_if.valid <= 1'b0;
                    @(negedge clk);
                end
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_unit();
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 3)) read_store(1'($urandom_range(1)));
            end
            else if (pick < 87)
            begin
                repeat ($urandom_range(1, 6)) stream_byte(payload_byte());
            end
            else if (pick < 92)
            begin
                push_request(ACT_UNKNOWN, 8'($urandom_range(255)), INDEX_W'($urandom_range(63)));
            end
            else
            begin
                // start code cut short by a stray byte
                repeat ($urandom_range(1, 2)) stream_byte(8'h00);
                stream_byte(8'($urandom_range(2, 255)));
            end
        end

        stream_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("annexb_parameter_set_extractor_core regression: pass");
        else
            $display("annexb_parameter_set_extractor_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/apse_pkg.sv
rtl/core/apse_in_if.sv
rtl/core/apse_out_if.sv
rtl/core/apse_ram.sv
rtl/core/annexb_parameter_set_extractor_core.sv
bench/apse_stream_checker.sv
bench/testbench.sv
